// ===== hdl/f2dt_pkg.sv =====
// Shared types and constants for the float to decimal text formatter.
`default_nettype none
package f2dt_pkg;

	// Width of the saturated whole part.
	localparam int WholeW = 31;

	// Largest whole part; larger magnitudes, infinities and NaN clamp to it.
	localparam logic [WholeW-1:0] WHOLE_SAT = 31'h7FFF_FFFF;

	// Most decimal digits a whole part can have.
	localparam int WholeDigits = 10;
	localparam int DigIdxW = 4;

	// Reciprocal of ten scaled by 2^35, exact for any 32-bit dividend.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int Recip10Shift = 35;

	// Exponent codes of the single-precision format.
	localparam logic [7:0] EXP_SPECIAL = 8'd255;
	localparam logic [7:0] EXP_SAT_MIN = 8'd158;
	localparam logic [7:0] EXP_BIAS_INT = 8'd150;

	// ASCII codes.
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Classified number handed from the front to the back.
	typedef struct packed {
		logic neg;
		logic ovf;
		logic [WholeW-1:0] whole;
	} cls_t;

	localparam int ClsW = $bits(cls_t);

endpackage
`default_nettype wire

// ===== hdl/f2dt_front.sv =====
// Front end: takes the input word and converts it to sign, whole part and fixed-point fraction.
`default_nettype none
module f2dt_front #(
	parameter int FIXED_FRACTION_BITS = 40
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire logic [31:0]                    value_bits,
	output      logic                           push,
	output      f2dt_pkg::cls_t                 push_cls,
	output      logic [FIXED_FRACTION_BITS-1:0] push_frac,
	input  wire logic                           full
);

	localparam int ExtW = 24 + FIXED_FRACTION_BITS;

	logic        pend_q;
	logic [31:0] val_q;
	logic        accept;

	logic       sign;
	logic [7:0] ex;
	logic [22:0] man;
	logic [23:0] sig;
	logic [7:0] ex_eff;
	logic [7:0] rsh;
	logic [2:0] lsh;
	logic [ExtW-1:0] ext;

	// A held word waits only while the queue is full.
	assign busy   = pend_q && full;
	assign accept = start && !busy;
	assign push   = pend_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (push) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value_bits;
		end
	end

	// Field split and significand alignment.
	assign sign   = val_q[31];
	assign ex     = val_q[30:23];
	assign man    = val_q[22:0];
	assign sig    = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
	assign ex_eff = (ex == 8'd0) ? 8'd1 : ex;
	assign rsh    = f2dt_pkg::EXP_BIAS_INT - ex_eff;
	assign lsh    = 3'(ex - f2dt_pkg::EXP_BIAS_INT);
	assign ext    = {sig, {FIXED_FRACTION_BITS{1'b0}}} >> rsh;

	// Classification: saturating cases first, then integer or fractional scaling.
	always_comb begin
		push_cls.neg   = 1'b0;
		push_cls.ovf   = 1'b0;
		push_cls.whole = '0;
		push_frac      = '0;
		if (ex == f2dt_pkg::EXP_SPECIAL) begin
			push_cls.ovf   = 1'b1;
			push_cls.whole = f2dt_pkg::WHOLE_SAT;
			push_cls.neg   = sign && (man == 23'd0);
		end else if (ex >= f2dt_pkg::EXP_SAT_MIN) begin
			push_cls.ovf   = 1'b1;
			push_cls.whole = f2dt_pkg::WHOLE_SAT;
			push_cls.neg   = sign;
		end else begin
			push_cls.neg = sign && (sig != 24'd0);
			if (ex >= f2dt_pkg::EXP_BIAS_INT) begin
				push_cls.whole = {7'd0, sig} << lsh;
			end else begin
				push_cls.whole = {7'd0, ext[ExtW-1:FIXED_FRACTION_BITS]};
				push_frac      = ext[FIXED_FRACTION_BITS-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/f2dt_queue.sv =====
// Two-entry queue between the front end and the character sequencer.
`default_nettype none
module f2dt_queue #(
	parameter int W = 73
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output      logic         full,
	input  wire logic         pop,
	output      logic [W-1:0] pop_data,
	output      logic         empty
);

	logic [W-1:0] mem [0:1];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/f2dt_back.sv =====
// Back end: splits the whole part into decimal digits, then sends the text one character a cycle.
`default_nettype none
module f2dt_back #(
	parameter int FRACTION_DIGITS     = 5,
	parameter int FIXED_FRACTION_BITS = 40
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           empty,
	output      logic                           pop,
	input  wire f2dt_pkg::cls_t                 pop_cls,
	input  wire logic [FIXED_FRACTION_BITS-1:0] pop_frac,
	output      logic                           strobe,
	output      logic [7:0]                     character,
	output      logic                           last,
	output      logic                           overflow
);

	localparam int FcntW = $clog2(FRACTION_DIGITS + 1);
	localparam int FB = FIXED_FRACTION_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_WHOLE = 3'd2;
	localparam logic [2:0] ST_DOT   = 3'd3;
	localparam logic [2:0] ST_FRAC  = 3'd4;

	logic [2:0]                  state_q;
	logic [f2dt_pkg::WholeW-1:0] whole_q;
	logic [FB-1:0]               frac_q;
	logic                        neg_q;
	logic                        ovf_q;
	logic [f2dt_pkg::DigIdxW-1:0] cnt_q;
	logic [FcntW-1:0]            fcnt_q;
	logic [3:0]                  dig_q [0:f2dt_pkg::WholeDigits-1];

	logic                        strobe_q;
	logic [7:0]                  char_q;
	logic                        last_q;
	logic                        ovf_out_q;

	logic [62:0]                 prod;
	logic [27:0]                 quot;
	logic [f2dt_pkg::WholeW-1:0] quot10;
	logic [f2dt_pkg::WholeW-1:0] rem_whole;
	logic [FB+3:0]               ften;
	logic                        frac_last;

	// Divide by ten through the scaled reciprocal.
	assign prod      = {32'd0, whole_q} * {31'd0, f2dt_pkg::RECIP10};
	assign quot      = prod[62:f2dt_pkg::Recip10Shift];
	assign quot10    = {quot, 3'd0} + {2'd0, quot, 1'd0};
	assign rem_whole = whole_q - quot10;

	// Next fraction digit: ten times the fraction, the carry out is the digit.
	assign ften      = {1'b0, frac_q, 3'd0} + {3'd0, frac_q, 1'd0};
	assign frac_last = (ften[FB-1:0] == '0) || (fcnt_q == FcntW'(FRACTION_DIGITS - 1));

	assign pop = !empty && ((state_q == ST_IDLE) || ((state_q == ST_FRAC) && frac_last));

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;
	assign overflow  = ovf_out_q;

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			fcnt_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// The sign goes out while the first digit is computed.
					if ((cnt_q == '0) && neg_q) begin
						strobe_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (quot == 28'd0) begin
						state_q <= ST_WHOLE;
					end
				end
				ST_WHOLE: begin
					strobe_q <= 1'b1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == f2dt_pkg::DigIdxW'(1)) begin
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					strobe_q <= 1'b1;
					fcnt_q   <= '0;
					state_q  <= ST_FRAC;
				end
				ST_FRAC: begin
					strobe_q <= 1'b1;
					if (frac_last) begin
						cnt_q   <= '0;
						state_q <= pop ? ST_DIV : ST_IDLE;
					end else begin
						fcnt_q <= fcnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working values and the output word.
	always_ff @(posedge clk) begin
		if (pop) begin
			whole_q <= pop_cls.whole;
			frac_q  <= pop_frac;
			neg_q   <= pop_cls.neg;
			ovf_q   <= pop_cls.ovf;
		end
		unique case (state_q)
			ST_DIV: begin
				dig_q[cnt_q] <= rem_whole[3:0];
				whole_q      <= {3'd0, quot};
				char_q       <= f2dt_pkg::CHAR_MINUS;
				last_q       <= 1'b0;
				ovf_out_q    <= ovf_q;
			end
			ST_WHOLE: begin
				char_q    <= f2dt_pkg::CHAR_ZERO + {4'd0, dig_q[cnt_q - 1'b1]};
				last_q    <= 1'b0;
				ovf_out_q <= ovf_q;
			end
			ST_DOT: begin
				char_q    <= f2dt_pkg::CHAR_DOT;
				last_q    <= 1'b0;
				ovf_out_q <= ovf_q;
			end
			ST_FRAC: begin
				char_q    <= f2dt_pkg::CHAR_ZERO + {4'd0, ften[FB+3:FB]};
				last_q    <= frac_last;
				ovf_out_q <= ovf_q;
				if (!pop) begin
					frac_q <= ften[FB-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/float_to_decimal_text_core.sv =====
// Top level: formats a single-precision value as decimal ASCII text, one character a cycle once the
// whole digits are computed. A word is registered in the front end, queued, then loaded by the
// sequencer; a '-' goes out while the first digit is computed. Per item the sequencer divides by ten
// once per whole digit, sends the whole digits, the point and the fraction digits, and then loads the
// next word, a step that is hidden when the next word is already queued.
// Reset clears the queue and the sequencer at once; the receiver cannot stall.
`default_nettype none
module float_to_decimal_text_core #(
	parameter int FRACTION_DIGITS     = 5,
	parameter int FIXED_FRACTION_BITS = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [31:0] value_bits,
	output      logic        strobe,
	output      logic [7:0]  character,
	output      logic        last,
	output      logic        overflow
);

	localparam int QW = f2dt_pkg::ClsW + FIXED_FRACTION_BITS;

	logic                           push;
	f2dt_pkg::cls_t                 push_cls;
	logic [FIXED_FRACTION_BITS-1:0] push_frac;
	logic                           full;
	logic                           pop;
	logic [QW-1:0]                  pop_data;
	logic                           empty;
	f2dt_pkg::cls_t                 pop_cls;
	logic [FIXED_FRACTION_BITS-1:0] pop_frac;

	assign pop_cls  = pop_data[QW-1:FIXED_FRACTION_BITS];
	assign pop_frac = pop_data[FIXED_FRACTION_BITS-1:0];

	f2dt_front #(
		.FIXED_FRACTION_BITS(FIXED_FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value_bits(value_bits),
		.push      (push),
		.push_cls  (push_cls),
		.push_frac (push_frac),
		.full      (full)
	);

	f2dt_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_cls, push_frac}),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	f2dt_back #(
		.FRACTION_DIGITS    (FRACTION_DIGITS),
		.FIXED_FRACTION_BITS(FIXED_FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop      (pop),
		.pop_cls  (pop_cls),
		.pop_frac (pop_frac),
		.strobe   (strobe),
		.character(character),
		.last     (last),
		.overflow (overflow)
	);

endmodule
`default_nettype wire
